### hdl/mbrtu_pkg.sv
`timescale 1ns / 1ps
package mbrtu_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] first_register;
    logic [4:0]  register_count;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_FAIL    = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_CRC     = 2'd3;

  localparam logic [0:0] REG_ADDR    = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CRC,
    ST_TX,
    ST_PAYLOAD,
    ST_EMIT
  } state_t;

endpackage

### hdl/modbus_rtu_read_transaction_unit.sv
`timescale 1ns / 1ps
// Modbus RTU read-holding-registers master. Input items are start (op 0), received
// byte (op 1) and millisecond tick (op 2); results are transmit bytes, payload bytes,
// done and failed. The CRC-16 runs one bit a cycle. A received byte is decoded, runs
// eight CRC steps and returns to idle; the last byte of a frame instead sends the
// payload bytes from the internal store and the done result if the frame is good, else
// it resends the request. A tick fails the transaction, resends the request or returns
// to idle. A request runs eight CRC steps on each of its six header bytes, then sends
// two CRC bytes. One item is worked on at a time; results leave through a single output
// register and the input stalls until the last result of the item is in that register.
module modbus_rtu_read_transaction_unit #(
  parameter int MAX_REGISTERS = 16,
  parameter int RETRY_MS      = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mbrtu_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbrtu_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);

  localparam int DEPTH = 2 * MAX_REGISTERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0]  MAXC  = 5'(MAX_REGISTERS);
  localparam logic [15:0] RETRY = 16'(RETRY_MS);

  // configuration
  logic [7:0]  dev_addr_r;
  logic [15:0] timeout_r;

  // transaction state
  mbrtu_pkg::state_t state_r, state_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] first_reg_r, first_reg_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;     // receive CRC
  logic [15:0] tcrc_r, tcrc_nxt;     // transmit CRC
  logic [5:0]  rxcnt_r, rxcnt_nxt;
  logic [15:0] overall_r, overall_nxt;
  logic [15:0] attempt_r, attempt_nxt;
  logic [1:0]  lasterr_r, lasterr_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;

  // bit-serial work registers
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [2:0]  txi_r, txi_nxt;       // request byte index
  logic        crc_sel_r, crc_sel_nxt; // 1: transmit CRC
  logic        frame_end_r, frame_end_nxt;
  logic [AW:0] pidx_r, pidx_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  mbrtu_pkg::out_item_t od_r, od_nxt;

  // payload store
  logic [7:0]    store [DEPTH];
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_rdata;
  logic [AW-1:0] st_raddr;

  logic [4:0]  cnt_clamp;
  logic [5:0]  two_cnt;
  logic [15:0] crc_cur, crc_step;
  logic [7:0]  tx_byte;
  logic        out_free;

  assign in_stall  = (state_r != mbrtu_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_free  = !ov_r || !out_stall;
  assign two_cnt   = {count_r, 1'b0};

  always_comb begin
    cnt_clamp = in_data.register_count;
    if (cnt_clamp == 5'd0) cnt_clamp = 5'd1;
    if (cnt_clamp > MAXC) cnt_clamp = MAXC;
  end

  // request byte for the current index
  always_comb begin
    case (txi_r)
      3'd0:    tx_byte = dev_addr_r;
      3'd1:    tx_byte = mbrtu_pkg::FUNC_READ;
      3'd2:    tx_byte = first_reg_r[15:8];
      3'd3:    tx_byte = first_reg_r[7:0];
      3'd4:    tx_byte = 8'd0;
      3'd5:    tx_byte = {3'd0, count_r};
      3'd6:    tx_byte = tcrc_r[7:0];
      default: tx_byte = tcrc_r[15:8];
    endcase
  end

  // one CRC bit step
  always_comb begin
    crc_cur  = crc_sel_r ? tcrc_r : rcrc_r;
    crc_step = crc_cur[0] ? ((crc_cur >> 1) ^ mbrtu_pkg::CRC_POLY) : (crc_cur >> 1);
  end

  assign st_raddr = pidx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= byte_r;
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      timeout_r  <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbrtu_pkg::REG_ADDR:    dev_addr_r <= cfg_wdata[7:0];
        mbrtu_pkg::REG_TIMEOUT: timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mbrtu_pkg::ST_IDLE;
      phase_r   <= 1'b0;
      first_reg_r <= '0;
      count_r   <= '0;
      rcrc_r    <= mbrtu_pkg::CRC_INIT;
      tcrc_r    <= '0;
      rxcnt_r   <= '0;
      overall_r <= '0;
      attempt_r <= '0;
      lasterr_r <= mbrtu_pkg::ERR_TIMEOUT;
      hdr_bad_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      first_reg_r <= first_reg_nxt;
      count_r   <= count_nxt;
      rcrc_r    <= rcrc_nxt;
      tcrc_r    <= tcrc_nxt;
      rxcnt_r   <= rxcnt_nxt;
      overall_r <= overall_nxt;
      attempt_r <= attempt_nxt;
      lasterr_r <= lasterr_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    bit_r       <= bit_nxt;
    txi_r       <= txi_nxt;
    crc_sel_r   <= crc_sel_nxt;
    frame_end_r <= frame_end_nxt;
    pidx_r      <= pidx_nxt;
    od_r        <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    first_reg_nxt = first_reg_r;
    count_nxt = count_r;
    rcrc_nxt = rcrc_r;
    tcrc_nxt = tcrc_r;
    rxcnt_nxt = rxcnt_r;
    overall_nxt = overall_r;
    attempt_nxt = attempt_r;
    lasterr_nxt = lasterr_r;
    hdr_bad_nxt = hdr_bad_r;
    byte_nxt = byte_r;
    bit_nxt = bit_r;
    txi_nxt = txi_r;
    crc_sel_nxt = crc_sel_r;
    frame_end_nxt = frame_end_r;
    pidx_nxt = pidx_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    st_we = 1'b0;
    st_waddr = rxcnt_r[AW-1:0] - AW'(3);

    // drain the output register
    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      mbrtu_pkg::ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.rx_byte;
          state_nxt = mbrtu_pkg::ST_DECODE;
        end
        // hold the item fields by capturing them now
        if (in_valid && in_data.operation == mbrtu_pkg::OP_START) begin
          first_reg_nxt = in_data.first_register;
          count_nxt = cnt_clamp;
          lasterr_nxt = mbrtu_pkg::ERR_TIMEOUT;
          overall_nxt = '0;
          if (timeout_r == 16'd0) begin
            phase_nxt = 1'b0;
            bit_nxt = 4'd0;
            state_nxt = mbrtu_pkg::ST_EMIT;
          end else begin
            phase_nxt = 1'b1;
            state_nxt = mbrtu_pkg::ST_TX;
            txi_nxt = 3'd0;
            bit_nxt = 4'd0;
            tcrc_nxt = mbrtu_pkg::CRC_INIT;
            rcrc_nxt = mbrtu_pkg::CRC_INIT;
            rxcnt_nxt = '0;
            hdr_bad_nxt = 1'b0;
            attempt_nxt = '0;
          end
        end else if (in_valid && in_data.operation == mbrtu_pkg::OP_BYTE && phase_r) begin
          state_nxt = mbrtu_pkg::ST_DECODE;
        end else if (in_valid && in_data.operation == mbrtu_pkg::OP_TICK && phase_r) begin
          if (overall_r != 16'hFFFF) overall_nxt = overall_r + 16'd1;
          if (attempt_r != 16'hFFFF) attempt_nxt = attempt_r + 16'd1;
          state_nxt = mbrtu_pkg::ST_EMIT;
          frame_end_nxt = 1'b1; // EMIT does not read this; it decides on bit_r 15
          bit_nxt = 4'd15;
        end else if (in_valid) begin
          state_nxt = mbrtu_pkg::ST_IDLE;
        end
      end

      // received byte: header check and store write, then CRC
      mbrtu_pkg::ST_DECODE: begin
        if (rxcnt_r == 6'd0 && byte_r != dev_addr_r) hdr_bad_nxt = 1'b1;
        if (rxcnt_r == 6'd1 && byte_r != mbrtu_pkg::FUNC_READ) hdr_bad_nxt = 1'b1;
        if (rxcnt_r == 6'd2 && byte_r != {2'd0, two_cnt}) hdr_bad_nxt = 1'b1;
        if (rxcnt_r >= 6'd3 && rxcnt_r < 6'd3 + two_cnt) st_we = 1'b1;
        rcrc_nxt = rcrc_r ^ {8'd0, byte_r};
        crc_sel_nxt = 1'b0;
        bit_nxt = 4'd0;
        frame_end_nxt = (rxcnt_r + 6'd1 >= 6'd5 + two_cnt);
        rxcnt_nxt = rxcnt_r + 6'd1;
        state_nxt = mbrtu_pkg::ST_CRC;
      end

      mbrtu_pkg::ST_CRC: begin
        rcrc_nxt = crc_step;
        bit_nxt = bit_r + 4'd1;
        if (bit_r == 4'd7) begin
          if (!frame_end_r) begin
            state_nxt = mbrtu_pkg::ST_IDLE;
          end else if (hdr_bad_r || crc_step != 16'd0) begin
            lasterr_nxt = hdr_bad_r ? mbrtu_pkg::ERR_INVALID : mbrtu_pkg::ERR_CRC;
            state_nxt = mbrtu_pkg::ST_TX;
            txi_nxt = 3'd0;
            bit_nxt = 4'd0;
            tcrc_nxt = mbrtu_pkg::CRC_INIT;
          end else begin
            pidx_nxt = '0;
            bit_nxt = 4'd0;
            state_nxt = mbrtu_pkg::ST_PAYLOAD;
          end
        end
      end

      // request: bit 0 loads, bits 1..8 run CRC for bytes 0..5, then emit
      mbrtu_pkg::ST_TX: begin
        crc_sel_nxt = 1'b1;
        if (bit_r == 4'd0) begin
          if (txi_r < 3'd6) tcrc_nxt = tcrc_r ^ {8'd0, tx_byte};
          bit_nxt = (txi_r < 3'd6) ? 4'd1 : 4'd9;
        end else if (bit_r < 4'd9) begin
          tcrc_nxt = crc_step;
          bit_nxt = bit_r + 4'd1;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{kind: mbrtu_pkg::KIND_TX, data_byte: tx_byte,
                     error_code: mbrtu_pkg::ERR_NONE, last: (txi_r == 3'd7)};
          bit_nxt = 4'd0;
          txi_nxt = txi_r + 3'd1;
          if (txi_r == 3'd7) begin
            rcrc_nxt = mbrtu_pkg::CRC_INIT;
            rxcnt_nxt = '0;
            hdr_bad_nxt = 1'b0;
            attempt_nxt = '0;
            state_nxt = mbrtu_pkg::ST_IDLE;
          end
        end
      end

      // payload: bit_r 0 waits for the store read, 1 emits
      mbrtu_pkg::ST_PAYLOAD: begin
        if (pidx_r == (AW+1)'(two_cnt)) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            od_nxt = '{kind: mbrtu_pkg::KIND_DONE, data_byte: 8'd0,
                       error_code: mbrtu_pkg::ERR_NONE, last: 1'b1};
            phase_nxt = 1'b0;
            rxcnt_nxt = '0;
            rcrc_nxt = mbrtu_pkg::CRC_INIT;
            hdr_bad_nxt = 1'b0;
            state_nxt = mbrtu_pkg::ST_IDLE;
          end
        end else if (bit_r == 4'd0) begin
          bit_nxt = 4'd1;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{kind: mbrtu_pkg::KIND_PAYLOAD, data_byte: st_rdata,
                     error_code: mbrtu_pkg::ERR_NONE, last: 1'b0};
          pidx_nxt = pidx_r + (AW+1)'(1);
          bit_nxt = 4'd0;
        end
      end

      // single result: timeout fail, or tick decision
      mbrtu_pkg::ST_EMIT: begin
        if (bit_r == 4'd15) begin
          bit_nxt = 4'd0;
          if (overall_r >= timeout_r) begin
            phase_nxt = 1'b0;
            rxcnt_nxt = '0;
            rcrc_nxt = mbrtu_pkg::CRC_INIT;
            hdr_bad_nxt = 1'b0;
          end else if (attempt_r >= RETRY) begin
            state_nxt = mbrtu_pkg::ST_TX;
            txi_nxt = 3'd0;
            tcrc_nxt = mbrtu_pkg::CRC_INIT;
          end else begin
            state_nxt = mbrtu_pkg::ST_IDLE;
          end
        end else if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{kind: mbrtu_pkg::KIND_FAIL, data_byte: 8'd0,
                     error_code: lasterr_r, last: 1'b1};
          state_nxt = mbrtu_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mbrtu_pkg::ST_IDLE;
    endcase
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mbrtu_pkg::ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(od_r)))
    else $error("stalled result changed");
  a_done_ends_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrtu_pkg::ST_PAYLOAD && state_nxt == mbrtu_pkg::ST_IDLE) |=> !phase_r)
    else $error("phase still open after done");
  a_rxcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (rxcnt_r <= 6'd5 + two_cnt))
    else $error("receive count overran frame");

endmodule

### tb/sv/modbus_rtu_read_transaction_unit_test.sv
`timescale 1ns / 1ps
module modbus_rtu_read_transaction_unit_test;

  localparam int MAX_REGS   = 16;
  localparam int RETRY_TICK = 100;
  localparam int DRAIN_WAIT = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  mbrtu_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  mbrtu_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [0:0]           cfg_index;
  logic [15:0]          cfg_wdata;

  modbus_rtu_read_transaction_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Transaction state as the block should hold it
  logic [7:0]  exp_addr;
  logic [15:0] exp_timeout;
  logic        txn_busy;
  logic [15:0] txn_first;
  logic [4:0]  txn_count;
  logic [15:0] rx_crc;
  logic [5:0]  rx_bytes;
  logic [15:0] total_ms;
  logic [15:0] attempt_ms;
  logic [1:0]  attempt_err;
  logic [7:0]  frame_store [0:2*MAX_REGS-1];
  logic        header_wrong;

  mbrtu_pkg::out_item_t expected_results[$];
  mbrtu_pkg::out_item_t newest_first;
  int                   newest_n;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  logic hold_go;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [7:0] d, logic [1:0] e);
    mbrtu_pkg::out_item_t r;
    r.kind = k; r.data_byte = d; r.error_code = e; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Queue the eight request bytes and open a fresh attempt
  function automatic void queue_request();
    logic [7:0]  fr [0:5];
    logic [15:0] crc;
    fr[0] = exp_addr; fr[1] = mbrtu_pkg::FUNC_READ;
    fr[2] = txn_first[15:8]; fr[3] = txn_first[7:0];
    fr[4] = 8'h00; fr[5] = {3'b000, txn_count};
    crc = mbrtu_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc_byte(crc, fr[i]);
      push_result(mbrtu_pkg::KIND_TX, fr[i], mbrtu_pkg::ERR_NONE);
    end
    push_result(mbrtu_pkg::KIND_TX, crc[7:0], mbrtu_pkg::ERR_NONE);
    push_result(mbrtu_pkg::KIND_TX, crc[15:8], mbrtu_pkg::ERR_NONE);
    rx_crc = mbrtu_pkg::CRC_INIT; rx_bytes = '0; header_wrong = 1'b0; attempt_ms = '0;
  endfunction

  function automatic void close_frame();
    rx_bytes = '0; rx_crc = mbrtu_pkg::CRC_INIT; header_wrong = 1'b0;
  endfunction

  // Work out the results of one accepted transfer
  function automatic void predict_transfer(mbrtu_pkg::in_item_t it);
    int n0, idx, span;
    mbrtu_pkg::out_item_t r;
    n0 = expected_results.size();
    span = 2 * txn_count;
    if (it.operation == mbrtu_pkg::OP_START) begin
      txn_count = (it.register_count == 0) ? 5'd1 :
                  (it.register_count > MAX_REGS) ? 5'(MAX_REGS) : it.register_count;
      txn_first = it.first_register;
      attempt_err = mbrtu_pkg::ERR_TIMEOUT;
      total_ms = '0;
      if (exp_timeout == 0) begin
        txn_busy = 1'b0;
        push_result(mbrtu_pkg::KIND_FAIL, 8'h00, attempt_err);
      end else begin
        txn_busy = 1'b1;
        queue_request();
      end
    end else if (it.operation == mbrtu_pkg::OP_BYTE && txn_busy) begin
      idx = int'(rx_bytes);
      if (idx == 0 && it.rx_byte != exp_addr) header_wrong = 1'b1;
      if (idx == 1 && it.rx_byte != mbrtu_pkg::FUNC_READ) header_wrong = 1'b1;
      if (idx == 2 && it.rx_byte != 8'(span)) header_wrong = 1'b1;
      if (idx >= 3 && idx < 3 + span) frame_store[idx-3] = it.rx_byte;
      rx_crc = crc_byte(rx_crc, it.rx_byte);
      rx_bytes = 6'(idx + 1);
      if (idx + 1 >= 5 + span) begin
        if (header_wrong) begin
          attempt_err = mbrtu_pkg::ERR_INVALID;
          queue_request();
        end else if (rx_crc != 0) begin
          attempt_err = mbrtu_pkg::ERR_CRC;
          queue_request();
        end else begin
          for (int i = 0; i < span; i++)
            push_result(mbrtu_pkg::KIND_PAYLOAD, frame_store[i], mbrtu_pkg::ERR_NONE);
          push_result(mbrtu_pkg::KIND_DONE, 8'h00, mbrtu_pkg::ERR_NONE);
          txn_busy = 1'b0;
          close_frame();
        end
      end
    end else if (it.operation == mbrtu_pkg::OP_TICK && txn_busy) begin
      if (total_ms != 16'hFFFF) total_ms++;
      if (attempt_ms != 16'hFFFF) attempt_ms++;
      if (total_ms >= exp_timeout) begin
        txn_busy = 1'b0;
        close_frame();
        push_result(mbrtu_pkg::KIND_FAIL, 8'h00, attempt_err);
      end else if (attempt_ms >= RETRY_TICK) begin
        queue_request();
      end
    end
    newest_n = expected_results.size() - n0;
    if (newest_n > 0) begin
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
      newest_first = expected_results[n0];
    end
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    mbrtu_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind != want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.data_byte != want.data_byte)
          report_mismatch($sformatf("data %h, want %h", out_data.data_byte, want.data_byte));
        if (out_data.error_code != want.error_code)
          report_mismatch($sformatf("error %0d, want %0d", out_data.error_code,
                                    want.error_code));
        if (out_data.last != want.last)
          report_mismatch($sformatf("last %0d, want %0d", out_data.last, want.last));
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic send_item(mbrtu_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_transfer(it);
    items_sent++;
  endtask

  function automatic mbrtu_pkg::in_item_t noise_item(logic [1:0] op);
    mbrtu_pkg::in_item_t it;
    it.operation      = op;
    it.first_register = 16'($urandom);
    it.register_count = 5'($urandom);
    it.rx_byte        = 8'($urandom);
    return it;
  endfunction

  task automatic send_op(logic [1:0] op, logic [7:0] b);
    mbrtu_pkg::in_item_t it;
    it = noise_item(op);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_start(logic [15:0] first, logic [4:0] cnt);
    mbrtu_pkg::in_item_t it;
    it = noise_item(mbrtu_pkg::OP_START);
    it.first_register = first;
    it.register_count = cnt;
    send_item(it);
  endtask

  // Hold the sender until every expected result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mbrtu_pkg::REG_ADDR) exp_addr = val[7:0];
    else exp_timeout = val;
  endtask

  // Response frame for the open transaction: 0 good, 1 bad header, 2 bad CRC, 3 cut short
  task automatic send_response(int mode);
    logic [7:0]  fr [0:36];
    logic [15:0] crc;
    int len, stop, k;
    len = 5 + 2 * txn_count;
    fr[0] = exp_addr; fr[1] = mbrtu_pkg::FUNC_READ; fr[2] = 8'(2 * txn_count);
    for (int i = 3; i < len - 2; i++) fr[i] = 8'($urandom);
    crc = mbrtu_pkg::CRC_INIT;
    for (int i = 0; i < len - 2; i++) crc = crc_byte(crc, fr[i]);
    fr[len-2] = crc[7:0]; fr[len-1] = crc[15:8];
    stop = len;
    if (mode == 1) begin
      k = $urandom_range(2);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end else if (mode == 2) begin
      k = $urandom_range(len - 1, 3);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end else if (mode == 3) begin
      stop = $urandom_range(len - 1, 1);
    end
    for (int i = 0; i < stop; i++) send_op(mbrtu_pkg::OP_BYTE, fr[i]);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_op(mbrtu_pkg::OP_TICK, 8'($urandom));
  endtask

  // Directed table
  typedef enum int { R_ITEM, R_CFG, R_GOOD, R_BADHDR, R_BADCRC, R_TICKS } row_kind_t;
  typedef struct {
    row_kind_t            kind;
    mbrtu_pkg::in_item_t  it;
    int                   arg;
    bit                   typed;
    mbrtu_pkg::out_item_t want;
  } row_t;

  localparam mbrtu_pkg::out_item_t NO_RESULT = '0;
  row_t rows [0:21];

  initial begin
    rows[0]  = '{R_ITEM, '{mbrtu_pkg::OP_BYTE, 16'h0000, 5'd0, 8'hFF}, 0, 0, NO_RESULT};
    rows[1]  = '{R_ITEM, '{mbrtu_pkg::OP_TICK, 16'hFFFF, 5'd31, 8'h00}, 0, 0, NO_RESULT};
    rows[2]  = '{R_ITEM, '{2'd3, 16'h5A5A, 5'd16, 8'hA5}, 0, 0, NO_RESULT};
    rows[3]  = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0001, 5'd0, 8'h00}, 0, 0, NO_RESULT};
    rows[4]  = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'h1234, 5'd3, 8'h00}, 0, 1,
                 '{mbrtu_pkg::KIND_FAIL, 8'h00, mbrtu_pkg::ERR_TIMEOUT, 1'b1}};
    rows[5]  = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0001, 5'd0, 8'h00}, 16'hFFFF, 0,
                 NO_RESULT};
    rows[6]  = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0000, 5'd0, 8'h00}, 16'h00FF, 0,
                 NO_RESULT};
    rows[7]  = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'hFFFF, 5'd0, 8'h00}, 0, 1,
                 '{mbrtu_pkg::KIND_TX, 8'hFF, mbrtu_pkg::ERR_NONE, 1'b0}};
    rows[8]  = '{R_GOOD, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 0, 0, NO_RESULT};
    rows[9]  = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'h0000, 5'd31, 8'h00}, 0, 0, NO_RESULT};
    rows[10] = '{R_BADHDR, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 0, 0, NO_RESULT};
    rows[11] = '{R_BADCRC, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 0, 0, NO_RESULT};
    rows[12] = '{R_GOOD, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 0, 0, NO_RESULT};
    rows[13] = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0001, 5'd0, 8'h00}, 3, 0, NO_RESULT};
    rows[14] = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'h8000, 5'd16, 8'h00}, 0, 0, NO_RESULT};
    rows[15] = '{R_BADCRC, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 0, 0, NO_RESULT};
    rows[16] = '{R_TICKS, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 3, 1,
                 '{mbrtu_pkg::KIND_FAIL, 8'h00, mbrtu_pkg::ERR_CRC, 1'b1}};
    rows[17] = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0000, 5'd0, 8'h00}, 0, 0, NO_RESULT};
    rows[18] = '{R_CFG, '{mbrtu_pkg::OP_START, 16'h0001, 5'd0, 8'h00}, 120, 0, NO_RESULT};
    rows[19] = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'h00F0, 5'd2, 8'h00}, 0, 0, NO_RESULT};
    rows[20] = '{R_ITEM, '{mbrtu_pkg::OP_START, 16'h0F0F, 5'd17, 8'h00}, 0, 0, NO_RESULT};
    rows[21] = '{R_TICKS, '{mbrtu_pkg::OP_START, 16'h0, 5'd0, 8'h0}, 120, 1,
                 '{mbrtu_pkg::KIND_FAIL, 8'h00, mbrtu_pkg::ERR_TIMEOUT, 1'b1}};
  end

  task automatic run_directed();
    for (int r = 0; r < $size(rows); r++) begin
      case (rows[r].kind)
        R_CFG: begin
          write_reg(rows[r].it.first_register[0], 16'(rows[r].arg));
        end
        R_ITEM: begin
          send_item(rows[r].it);
        end
        R_GOOD: begin
          send_response(0);
        end
        R_BADHDR: begin
          send_response(1);
        end
        R_BADCRC: begin
          send_response(2);
        end
        R_TICKS: begin
          send_ticks(rows[r].arg);
        end
      endcase
      if (rows[r].typed && (newest_n == 0 || newest_first != rows[r].want))
        report_mismatch($sformatf("row %0d predicted %h, table says %h",
                                  r, newest_first, rows[r].want));
    end
  endtask

  // One random transaction: a start, then a mostly well-formed exchange
  task automatic random_transaction();
    int pick;
    logic [4:0] cnt;
    pick = $urandom_range(99);
    if (pick < 10) cnt = 5'($urandom);
    else if (pick < 15) cnt = 5'(MAX_REGS);
    else cnt = 5'($urandom_range(4, 1));
    send_start(16'($urandom), cnt);
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_response(0);
    end else if (pick < 55) begin
      send_response(1);
      send_response(0);
    end else if (pick < 65) begin
      send_response(2);
      send_response($urandom_range(1) ? 0 : 2);
    end else if (pick < 72) begin
      send_response(3);
      send_ticks($urandom_range(RETRY_TICK + 5, 3));
      send_response(0);
    end else if (pick < 85) begin
      repeat ($urandom_range(6, 1)) send_item(noise_item(2'($urandom)));
    end else begin
      send_ticks($urandom_range(8, 1));
      send_response(0);
    end
  endtask

  task automatic run_phase(int n, bit pressure);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      random_transaction();
      if (pressure && items_sent > goal - n / 2) begin
        // Receiver holds off while the sender keeps offering
        in_valid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (3) random_transaction();
        drain();
        pressure = 0;
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = mbrtu_pkg::REG_ADDR;
    cfg_wdata = '0;
    hold_go = 1'b0;
    exp_addr = 8'd1;
    exp_timeout = 16'd1000;
    txn_busy = 1'b0;
    txn_first = '0;
    txn_count = '0;
    rx_crc = mbrtu_pkg::CRC_INIT;
    rx_bytes = '0;
    total_ms = '0;
    attempt_ms = '0;
    attempt_err = mbrtu_pkg::ERR_TIMEOUT;
    header_wrong = 1'b0;
    newest_n = 0;
    newest_first = '0;
    for (int i = 0; i < 2 * MAX_REGS; i++) frame_store[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default settings first, then the table
    tx_idle = 37; rx_idle = 52;
    send_start(16'h0102, 5'd2);
    send_response(0);
    run_directed();

    write_reg(mbrtu_pkg::REG_ADDR, 16'($urandom));
    write_reg(mbrtu_pkg::REG_TIMEOUT, 16'($urandom_range(400, 30)));
    run_phase(40, 1);

    tx_idle = 52; rx_idle = 37;
    write_reg(mbrtu_pkg::REG_ADDR, 16'h0000);
    write_reg(mbrtu_pkg::REG_TIMEOUT, 16'($urandom_range(200, 40)));
    run_phase(40, 0);

    tx_idle = 0; rx_idle = 0;
    write_reg(mbrtu_pkg::REG_ADDR, 16'hFFFF);
    write_reg(mbrtu_pkg::REG_TIMEOUT, 16'hFFFF);
    run_phase(40, 0);

    drain();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d input transfers and %0d result transfers over three idling mixes",
             items_sent, results_seen);
    $display("good, bad-header, bad-CRC and cut-short frames, retries and timeouts; %0d errors",
             errors);
    if (errors == 0) begin
      $display("[modbus_rtu_read_transaction_unit] OK");
    end else begin
      $display("[modbus_rtu_read_transaction_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("[modbus_rtu_read_transaction_unit] ERROR");
    $finish;
  end

endmodule
